// ===== src/obdpid_pkg.sv =====
// Package for the mode 01 PID reply decoder: quantity codes, header strings,
// character classes and the hex helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package obdpid_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned QTY_W   = 3;
  localparam int unsigned VALUE_W = 15;
  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned CNT_W   = $clog2(WIN_DEPTH + 1);

  // Quantity codes as they appear on the result port
  typedef enum logic [QTY_W-1:0] {
    QTY_TEMP      = 3'd0,
    QTY_AIR_FLOW  = 3'd1,
    QTY_RPM       = 3'd2,
    QTY_THROTTLE  = 3'd3,
    QTY_FUEL_TRIM = 3'd4,
    QTY_SPEED     = 3'd5
  } qty_e;

  // Headers, first character in the top byte
  localparam logic [31:0] HDR_TEMP      = "4105";
  localparam logic [31:0] HDR_FUEL_TRIM = "4106";
  localparam logic [31:0] HDR_SPEED     = "410D";
  localparam logic [31:0] HDR_THROTTLE  = "4111";
  localparam logic [31:0] HDR_AIR_FLOW  = "4110";
  localparam logic [31:0] HDR_RPM       = "410C";

  // Reciprocals for the constant divisions
  localparam logic [16:0] AF_RECIP  = 17'd83887;  // x / 100 for 16-bit x
  localparam int unsigned AF_SHIFT  = 23;
  localparam logic [12:0] THR_RECIP = 13'd6426;   // a * 100 / 255 for 8-bit a
  localparam int unsigned THR_SHIFT = 14;

  // Letter, digit or underscore
  function automatic logic is_word(input logic [CHAR_W-1:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  // Returns {valid, nibble}
  function automatic logic [4:0] hex_nib(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if ((c >= "0") && (c <= "9")) begin
      d = c - CHAR_W'("0");
      return {1'b1, d[3:0]};
    end else if ((c >= "A") && (c <= "F")) begin
      d = c - CHAR_W'("A") + CHAR_W'(10);
      return {1'b1, d[3:0]};
    end else if ((c >= "a") && (c <= "f")) begin
      d = c - CHAR_W'("a") + CHAR_W'(10);
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // Two characters as one byte; a pair with any non-hex character reads as 0
  function automatic logic [7:0] hex_pair(input logic [CHAR_W-1:0] hi,
                                          input logic [CHAR_W-1:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    h = hex_nib(hi);
    l = hex_nib(lo);
    if (h[4] && l[4]) begin
      return {h[3:0], l[3:0]};
    end
    return 8'd0;
  endfunction

endpackage

`default_nettype wire

// ===== src/obd_pid_response_decoder_top.sv =====
// Mode 01 PID reply decoder: ASCII bytes in, decoded quantities out.
// An accepted input beat passes through the input register and then the result register.
// Throughput: one byte per cycle; the input register and the result register
// each hold one beat, and a stall on the result side backs up one stage.
// Reset (async, active low) empties both stages and clears the window/count.
// Depends on obdpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obd_pid_response_decoder_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [obdpid_pkg::CHAR_W-1:0]         char_in_i,
  input  wire logic                                  end_of_chunk_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [obdpid_pkg::QTY_W-1:0]               quantity_o,
  output logic signed [obdpid_pkg::VALUE_W-1:0]      value_o
);
  import obdpid_pkg::*;

  // Input register
  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] char_q;
  logic              eoc_q;
  logic              in_accept;
  logic              advance;

  // Window state, entry 0 oldest
  logic [CHAR_W-1:0] win_q [WIN_DEPTH];
  logic [CHAR_W-1:0] win_d [WIN_DEPTH];
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Result register
  logic                      out_valid_q, out_valid_d;
  logic [QTY_W-1:0]          qty_q;
  logic signed [VALUE_W-1:0] val_q;

  // Decode
  logic [CHAR_W-1:0]         nw [WIN_DEPTH];
  logic [CNT_W-1:0]          cnt_new;
  logic                      kept;
  logic [31:0]               hdr8, hdr6;
  logic [7:0]                pa8, pb8, pa6;
  logic [32:0]               af_prod;
  logic [20:0]               thr_prod;
  logic signed [8:0]         ft_s;
  logic signed [15:0]        ft_p;
  logic signed [15:0]        ft_q;
  logic                      found;
  qty_e                      qty;
  logic signed [VALUE_W-1:0] val;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_in_i;
      eoc_q  <= end_of_chunk_i;
    end
  end

  // Window as it stands once this byte is shifted in
  assign kept = is_word(char_q);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      nw[i] = win_q[i+1];
    end
    nw[WIN_DEPTH-1] = char_q;
    cnt_new = (cnt_q < CNT_W'(WIN_DEPTH)) ? cnt_q + CNT_W'(1) : cnt_q;
  end

  assign hdr8 = {nw[0], nw[1], nw[2], nw[3]};
  assign hdr6 = {nw[2], nw[3], nw[4], nw[5]};
  assign pa8  = hex_pair(nw[4], nw[5]);
  assign pb8  = hex_pair(nw[6], nw[7]);
  assign pa6  = hex_pair(nw[6], nw[7]);

  assign af_prod  = 33'({pa8, pb8}) * 33'(AF_RECIP);
  assign thr_prod = 21'(pa6) * 21'(THR_RECIP);

  // Fuel trim: divide by 128 rounding toward zero
  assign ft_s = $signed({1'b0, pa6}) - 9'sd128;
  assign ft_p = 16'(ft_s) * 16'sd100;
  assign ft_q = ft_p[15] ? ((ft_p + 16'sd127) >>> 7) : (ft_p >>> 7);

  always_comb begin
    found = 1'b0;
    qty   = QTY_TEMP;
    val   = '0;
    if (kept && (cnt_new >= CNT_W'(8)) && (hdr8 == HDR_AIR_FLOW)) begin
      found = 1'b1;
      qty   = QTY_AIR_FLOW;
      val   = VALUE_W'(af_prod[32:AF_SHIFT]);
    end else if (kept && (cnt_new >= CNT_W'(8)) && (hdr8 == HDR_RPM)) begin
      found = 1'b1;
      qty   = QTY_RPM;
      val   = VALUE_W'({pa8, pb8[7:2]});
    end else if (kept && (cnt_new >= CNT_W'(6))) begin
      unique case (hdr6)
        HDR_TEMP: begin
          found = 1'b1;
          qty   = QTY_TEMP;
          val   = VALUE_W'(pa6) - VALUE_W'(40);
        end
        HDR_THROTTLE: begin
          found = 1'b1;
          qty   = QTY_THROTTLE;
          val   = VALUE_W'(thr_prod[20:THR_SHIFT]);
        end
        HDR_FUEL_TRIM: begin
          found = 1'b1;
          qty   = QTY_FUEL_TRIM;
          val   = VALUE_W'(ft_q);
        end
        HDR_SPEED: begin
          found = 1'b1;
          qty   = QTY_SPEED;
          val   = VALUE_W'(pa6);
        end
        default: begin
          found = 1'b0;
        end
      endcase
    end
  end

  // Window update: shift on a kept byte, clear after the last byte of a chunk
  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    if (advance) begin
      if (kept) begin
        win_d = nw;
        cnt_d = cnt_new;
      end
      if (eoc_q) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_d[i] = '0;
        end
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
    end
  end

  // Result register: reload whenever it is free or being drained
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = advance && found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && found) begin
      qty_q <= qty;
      val_q <= val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quantity_o  = qty_q;
  assign value_o     = val_q;

endmodule

`default_nettype wire

// ===== src/obdpid_checker.sv =====
// Port-level checks for the PID reply decoder, bound to its top level.
// Depends on obdpid_pkg and obd_pid_response_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module obdpid_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_valid_i,
  input wire logic                                  in_stall_o,
  input wire logic [obdpid_pkg::CHAR_W-1:0]         char_in_i,
  input wire logic                                  end_of_chunk_i,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_stall_i,
  input wire logic [obdpid_pkg::QTY_W-1:0]          quantity_o,
  input wire logic signed [obdpid_pkg::VALUE_W-1:0] value_o
);
  import obdpid_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quantity_o) && $stable(value_o))
    else $error("result beat changed while stalled");

  a_qty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quantity_o <= QTY_SPEED))
    else $error("quantity code out of range");

  a_fuel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (quantity_o == QTY_FUEL_TRIM) |->
      ($signed(value_o) >= -15'sd100) && ($signed(value_o) <= 15'sd99))
    else $error("fuel trim out of range");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (quantity_o == QTY_TEMP) |->
      ($signed(value_o) >= -15'sd40) && ($signed(value_o) <= 15'sd215))
    else $error("coolant temperature out of range");

  // Input stall only when the result side holds a stalled beat
  a_in_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

endmodule

bind obd_pid_response_decoder_top obdpid_checker u_obdpid_checker (.*);

`default_nettype wire

// ===== test/tb_obd_pid_response_decoder_top.sv =====
// Self-checking testbench for obd_pid_response_decoder_top: ASCII reply bytes
// in, decoded PID readings out, with random input gaps and output back-pressure.
// Depends on obdpid_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_obd_pid_response_decoder_top;

  import obdpid_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT     = 600;
  localparam int unsigned TAIL_CYCLES     = 10;
  localparam int unsigned ITEM_TARGET     = 1600;
  localparam int unsigned MAX_PRINTS      = 50;

  localparam logic [31:0] PID_COOLANT  = "4105";
  localparam logic [31:0] PID_TRIM     = "4106";
  localparam logic [31:0] PID_SPEED    = "410D";
  localparam logic [31:0] PID_THROTTLE = "4111";
  localparam logic [31:0] PID_MAF      = "4110";
  localparam logic [31:0] PID_ENGINE   = "410C";

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_PROMPT = ">";

  typedef struct {
    qty_e                      qty;
    logic signed [VALUE_W-1:0] val;
  } reading_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CHAR_W-1:0]         char_in_i;
  logic                      end_of_chunk_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [QTY_W-1:0]          quantity_o;
  logic signed [VALUE_W-1:0] value_o;

  reading_t    expected_readings[$];
  logic [7:0]  win_chars [WIN_DEPTH];
  int          kept_n;

  int unsigned mismatch_count;
  int unsigned beats_sent;
  int unsigned kept_beats;
  int unsigned chunks_sent;
  int unsigned readings_seen;
  int unsigned per_qty [6];
  int unsigned idle_cycles;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          hold_off_req;

  obd_pid_response_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_chunk_i (end_of_chunk_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .quantity_o     (quantity_o),
    .value_o        (value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_ident_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // Data byte at window position p; any non-hex character zeroes the pair
  function automatic int pair_at(input int p);
    int hi;
    int lo;
    hi = hex_value(win_chars[p]);
    lo = hex_value(win_chars[p+1]);
    if (hi < 0 || lo < 0) return 0;
    return hi * 16 + lo;
  endfunction

  function automatic bit head_is(input int p, input logic [31:0] h);
    return {win_chars[p], win_chars[p+1], win_chars[p+2], win_chars[p+3]} == h;
  endfunction

  function automatic void clear_window();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) win_chars[i] = 8'h00;
    kept_n = 0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] c, input bit eoc,
                                     output qty_e q,
                                     output logic signed [VALUE_W-1:0] v);
    int i;
    int a;
    int b;
    int r;
    bit hit;
    hit = 1'b0;
    r = 0;
    q = QTY_TEMP;
    if (is_ident_char(c)) begin
      for (i = 0; i < WIN_DEPTH - 1; i++) win_chars[i] = win_chars[i+1];
      win_chars[WIN_DEPTH-1] = c;
      if (kept_n < WIN_DEPTH) kept_n++;
      if (kept_n >= 8) begin
        a = pair_at(4);
        b = pair_at(6);
        if (head_is(0, PID_MAF)) begin
          q = QTY_AIR_FLOW; r = (a * 256 + b) / 100; hit = 1'b1;
        end else if (head_is(0, PID_ENGINE)) begin
          q = QTY_RPM; r = (a * 256 + b) / 4; hit = 1'b1;
        end
      end
      if (!hit && kept_n >= 6) begin
        a = pair_at(6);
        if (head_is(2, PID_COOLANT)) begin
          q = QTY_TEMP; r = a - 40; hit = 1'b1;
        end else if (head_is(2, PID_THROTTLE)) begin
          q = QTY_THROTTLE; r = (a * 100) / 255; hit = 1'b1;
        end else if (head_is(2, PID_TRIM)) begin
          // signed division truncates toward zero
          q = QTY_FUEL_TRIM; r = ((a - 128) * 100) / 128; hit = 1'b1;
        end else if (head_is(2, PID_SPEED)) begin
          q = QTY_SPEED; r = a; hit = 1'b1;
        end
      end
    end
    v = r[VALUE_W-1:0];
    if (eoc) clear_window();
    return hit;
  endfunction

  // ------------------------------------------------------------------ pacing

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : sink_pacing
    int unsigned run;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        run = pick_gap();
        out_stall_i <= 1'b1;
        repeat (run) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("unexpected reading qty=%0d value=%0d",
                                quantity_o, value_o));
      end else begin
        want = expected_readings.pop_front();
        if (quantity_o !== want.qty)
          flag_mismatch($sformatf("quantity %0d, wanted %0d (value %0d)",
                                  quantity_o, want.qty, want.val));
        if (value_o !== want.val)
          flag_mismatch($sformatf("value %0d, wanted %0d (quantity %0d)",
                                  value_o, want.val, want.qty));
        per_qty[want.qty]++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("obd_pid_response_decoder_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------- stimulus

  // Offer one byte, hold it until taken, then predict its reading
  task automatic send_beat(input logic [7:0] c, input bit eoc);
    int unsigned gap;
    reading_t r;
    gap = (src_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_in_i      <= c;
    end_of_chunk_i <= eoc;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_byte(c, eoc, r.qty, r.val)) expected_readings.push_back(r);
    beats_sent++;
    if (is_ident_char(c) || eoc) kept_beats++;
    if (eoc) chunks_sent++;
  endtask

  task automatic send_text(input string s, input bit close_chunk);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], close_chunk && (i == s.len() - 1));
  endtask

  task automatic quiet_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_hex_char();
    int unsigned n;
    if ($urandom_range(0, 11) == 0) begin
      // junk in the data field
      return ($urandom_range(0, 1) != 0) ? 8'($urandom_range("G", "Z")) : 8'("_");
    end
    n = $urandom_range(0, 15);
    if (n < 10) return 8'("0" + n);
    if ($urandom_range(0, 3) == 0) return 8'("a" + n - 10);
    return 8'("A" + n - 10);
  endfunction

  function automatic logic [31:0] pick_header(input int unsigned idx);
    case (idx)
      0:       return PID_COOLANT;
      1:       return PID_TRIM;
      2:       return PID_SPEED;
      3:       return PID_THROTTLE;
      4:       return PID_MAF;
      default: return PID_ENGINE;
    endcase
  endfunction

  task automatic send_random_chunk();
    logic [7:0]  bytes_q[$];
    logic [31:0] hdr;
    logic [7:0]  pid_lo;
    int unsigned n_replies;
    int unsigned k;
    int unsigned j;
    int unsigned n_data;
    bit          spaced;
    if ($urandom_range(0, 3) != 0) begin
      n_replies = $urandom_range(1, 4);
      for (k = 0; k < n_replies; k++) begin
        hdr    = pick_header($urandom_range(0, 5));
        n_data = (hdr == PID_MAF || hdr == PID_ENGINE) ? 2 : 1;
        spaced = $urandom_range(0, 1);
        pid_lo = hdr[7:0];
        // a lower-case PID letter is no header
        if ((pid_lo == "C" || pid_lo == "D") && $urandom_range(0, 11) == 0)
          pid_lo = pid_lo | 8'h20;
        if ($urandom_range(0, 3) == 0) begin
          bytes_q.push_back("0");
          bytes_q.push_back("1");
          bytes_q.push_back(hdr[15:8]);
          bytes_q.push_back(hdr[7:0]);
          bytes_q.push_back(CH_CR);
        end
        bytes_q.push_back(hdr[31:24]);
        bytes_q.push_back(hdr[23:16]);
        if (spaced) bytes_q.push_back(CH_SPACE);
        bytes_q.push_back(hdr[15:8]);
        bytes_q.push_back(pid_lo);
        for (j = 0; j < n_data; j++) begin
          if (spaced) bytes_q.push_back(CH_SPACE);
          bytes_q.push_back(rand_hex_char());
          bytes_q.push_back(rand_hex_char());
        end
        bytes_q.push_back(CH_CR);
      end
      if ($urandom_range(0, 1) != 0) bytes_q.push_back(CH_PROMPT);
      // cut the chunk short so a reply is left incomplete at the chunk end
      if ($urandom_range(0, 4) == 0)
        while (bytes_q.size() > 1 && $urandom_range(0, 3) != 0) void'(bytes_q.pop_back());
    end else begin
      n_data = $urandom_range(1, 12);
      for (j = 0; j < n_data; j++) begin
        if ($urandom_range(0, 5) == 0) begin
          bytes_q.push_back("4");
          bytes_q.push_back("1");
        end
        bytes_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (j = 0; j < bytes_q.size(); j++) send_beat(bytes_q[j], j == bytes_q.size() - 1);
  endtask

  // ------------------------------------------------------------------ tests

  task automatic test_pid_extremes();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_text("41 05 00", 1'b1);
    send_text("41 05 FF", 1'b1);
    send_text("41 06 00", 1'b1);
    send_text("41 06 7F", 1'b1);
    send_text("41 06 FF", 1'b1);
    send_text("41 0D 00", 1'b1);
    send_text("41 0D ff", 1'b1);
    send_text("41 11 00", 1'b1);
    send_text("41 11 FF", 1'b1);
    send_text("41 10 00 00", 1'b1);
    send_text("41 10 FF FF", 1'b1);
    send_text("41 0C FF FF", 1'b1);
    send_text("41 0C 1a F8", 1'b1);
  endtask

  task automatic test_special_cases();
    send_text("41 0D G7", 1'b1);
    send_text("41 0C Z1 FF", 1'b1);
    send_text("41 0c 1A F8", 1'b1);
    // high bytes are dropped and do not break the header
    send_text("41", 1'b0);
    send_beat(8'h80, 1'b0);
    send_text("0D", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("7F", 1'b1);
    // chunk ends before the data is complete, then the rest arrives
    send_text("41 0C 1A", 1'b1);
    send_text("F8", 1'b1);
    send_text("410D410D41", 1'b1);
    send_text("41104105FF", 1'b1);
    send_text("41", 1'b0);
    send_beat(CH_CR, 1'b0);
    send_text("0D 55", 1'b1);
    send_text("41_0D55", 1'b1);
    send_text("41 0D 33", 1'b0);
    send_beat(CH_CR, 1'b1);
  endtask

  task automatic test_output_hold_off();
    int unsigned k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_off_req = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_text("410D", 1'b0);
      send_beat(rand_hex_char(), 1'b0);
      send_beat(rand_hex_char(), k[0]);
    end
  endtask

  task automatic test_random_replies();
    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        src_idle_en  = $urandom_range(0, 1);
        sink_idle_en = $urandom_range(0, 1);
      end
      send_random_chunk();
    end
  endtask

  initial begin
    int unsigned drain_wait;
    in_valid_i     = 1'b0;
    char_in_i      = '0;
    end_of_chunk_i = 1'b0;
    rst_ni         = 1'b0;
    src_idle_en    = 1'b0;
    sink_idle_en   = 1'b0;
    hold_off_req   = 1'b0;
    mismatch_count = 0;
    beats_sent     = 0;
    kept_beats     = 0;
    chunks_sent    = 0;
    readings_seen  = 0;
    idle_cycles    = 0;
    per_qty        = '{default: 0};
    clear_window();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pid_extremes();
    test_special_cases();
    test_output_hold_off();
    test_random_replies();
    quiet_input();

    drain_wait = 0;
    while (expected_readings.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_readings.size() != 0)
      flag_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));

    $display("Sent %0d bytes (%0d kept or chunk-closing) in %0d chunks, %0d readings out",
             beats_sent, kept_beats, chunks_sent, readings_seen);
    $display("Readings: temp %0d, maf %0d, rpm %0d, throttle %0d, trim %0d, speed %0d",
             per_qty[QTY_TEMP], per_qty[QTY_AIR_FLOW], per_qty[QTY_RPM],
             per_qty[QTY_THROTTLE], per_qty[QTY_FUEL_TRIM], per_qty[QTY_SPEED]);
    if (mismatch_count == 0) begin
      $display("obd_pid_response_decoder_top: match");
    end else begin
      $display("obd_pid_response_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/obdpid_pkg.sv
src/obd_pid_response_decoder_top.sv
src/obdpid_checker.sv
test/tb_obd_pid_response_decoder_top.sv
